### src/c8008_pkg.sv
// ---------------------------------------------------------------------------
// c8008 package
// Command codes, status codes and sequencer states of the 8008-style core.
// ---------------------------------------------------------------------------
package c8008_pkg;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_EXEC   = 2'd1;
   localparam logic [1:0] CMD_SET_PC = 2'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_HALT    = 2'd1;
   localparam logic [1:0] ST_ILLEGAL = 2'd2;

   localparam logic [2:0] ALU_CMP = 3'd7;
   localparam logic [2:0] REG_M   = 3'd7;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OPCODE,
      S_OPER1,
      S_OPER2,
      S_DATA,
      S_DONE
   } state_type;

endpackage

### src/cpu8008_instruction_executor.sv
// ---------------------------------------------------------------------------
// cpu8008_instruction_executor
// 8008-style core: one byte memory, seven registers, flags and return stack.
// ---------------------------------------------------------------------------
// Load, set-PC and unused commands go from S_IDLE to S_DONE; an instruction
// passes S_OPCODE and S_OPER1, plus S_OPER2 or S_DATA for a one-byte operand
// or an M access and both for a two-byte address, on the single memory port.
// One command is in flight at a time; busy falls in the result strobe cycle.
// Synchronous reset clears registers, flags, PC and stack; memory is not
// cleared. The receiver cannot stall the result.
module cpu8008_instruction_executor
   import c8008_pkg::*;
#(
   parameter int ADDR_BITS   = 16,
   parameter int STACK_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_addr,
   input  logic [7:0]  req_data,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [1:0]  rsp_length,
   output logic [15:0] rsp_prog_counter,
   output logic [7:0]  rsp_accum,
   output logic        rsp_carry_flag,
   output logic        rsp_zero_flag,
   output logic        rsp_sign_flag,
   output logic        rsp_parity_flag
);

   localparam int SP_BITS = $clog2(STACK_DEPTH);

   logic [7:0] mem [2**ADDR_BITS];
   logic [7:0] rd_data_ff;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [7:0] mem_wdata;
   logic mem_we;
   logic mem_re;

   state_type state_ff, state_in;

   logic [7:0]  regs_ff [7];
   logic [15:0] pc_ff;
   logic [SP_BITS-1:0] sp_ff;
   logic [15:0] stack_ff [STACK_DEPTH];
   logic fc_ff, fz_ff, fs_ff, fp_ff;

   logic [1:0]  cmd_ff;
   logic [15:0] addr_ff;
   logic [7:0]  data_ff;
   logic [7:0]  op_ff;
   logic [7:0]  opr1_ff;
   logic [1:0]  status_ff;
   logic [1:0]  length_ff;
   logic        valid_ff;

   logic [1:0] grp;
   logic [2:0] mid, low;
   logic [15:0] hl;
   logic is_halt;
   logic cond_ok;
   logic flag_sel;

   assign grp = op_ff[7:6];
   assign mid = op_ff[5:3];
   assign low = op_ff[2:0];
   assign hl  = {regs_ff[5], regs_ff[6]};
   assign is_halt = (op_ff[7:1] == 7'd0) || (op_ff == 8'hff);

   always_comb begin
      case (mid[1:0])
         2'd0:    flag_sel = fc_ff;
         2'd1:    flag_sel = fz_ff;
         2'd2:    flag_sel = fs_ff;
         default: flag_sel = fp_ff;
      endcase
      cond_ok = mid[2] ? flag_sel : !flag_sel;
   end

   // Operand byte count of the fetched opcode; the jump/call group
   // always fetches two operands, also for its illegal codes.
   logic [1:0] n_opr;
   logic needs_m;
   always_comb begin
      n_opr = 2'd0;
      needs_m = 1'b0;
      if (!is_halt) begin
         unique case (grp)
            2'd0: if (low == 3'd4 || low == 3'd6) n_opr = 2'd1;
            2'd1: n_opr = 2'd2;
            2'd2: needs_m = (low == REG_M);
            default: needs_m = (low == REG_M) || (mid == REG_M);
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:   if (start) state_in = (req_cmd == CMD_EXEC) ? S_OPCODE : S_DONE;
         S_OPCODE: state_in = S_OPER1;
         S_OPER1: begin
            if (n_opr != 2'd0) state_in = S_OPER2;
            else if (needs_m) state_in = S_DATA;
            else state_in = S_DONE;
         end
         S_OPER2: state_in = (n_opr == 2'd2) ? S_DATA : S_DONE;
         S_DATA:  state_in = S_DONE;
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Memory port control. The opcode is captured into op_ff in S_OPCODE, so
   // decode uses op_ff from S_OPER1 onward.
   logic [15:0] pc_plus;
   always_comb begin
      mem_we = 1'b0;
      mem_re = 1'b0;
      mem_addr = pc_ff[ADDR_BITS-1:0];
      mem_wdata = data_ff;
      pc_plus = pc_ff + 16'd1;
      unique case (state_ff)
         S_IDLE: begin
            if (start && req_cmd == CMD_EXEC) mem_re = 1'b1;
         end
         S_OPER1: begin
            mem_re = 1'b1;
            if (n_opr != 2'd0) mem_addr = pc_plus[ADDR_BITS-1:0];
            else mem_addr = hl[ADDR_BITS-1:0];
            if (!is_halt && grp == 2'd3 && low != REG_M && mid == REG_M) begin
               mem_re = 1'b0;
               mem_we = 1'b1;
               mem_wdata = regs_ff[low];
            end
         end
         S_OPER2: begin
            // A single operand byte must stay in rd_data_ff until S_DONE.
            mem_re = (n_opr == 2'd2);
            mem_addr = pc_ff[ADDR_BITS-1:0] + ADDR_BITS'(2);
         end
         S_DONE: begin
            if (cmd_ff == CMD_LOAD) begin
               mem_we = 1'b1;
               mem_addr = addr_ff[ADDR_BITS-1:0];
            end else if (cmd_ff == CMD_EXEC && !is_halt && grp == 2'd0 &&
                         low == 3'd6 && mid == REG_M) begin
               mem_we = 1'b1;
               mem_addr = hl[ADDR_BITS-1:0];
               mem_wdata = rd_data_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_addr] <= mem_wdata;
      if (mem_re) rd_data_ff <= mem[mem_addr];
   end

   // ALU.
   logic [7:0] alu_src;
   logic [8:0] alu_r;
   always_comb begin
      alu_src = (grp == 2'd0) ? rd_data_ff : ((low == REG_M) ? rd_data_ff : regs_ff[low]);
      case (mid)
         3'd0:    alu_r = {1'b0, regs_ff[0]} + {1'b0, alu_src};
         3'd1:    alu_r = {1'b0, regs_ff[0]} + {1'b0, alu_src} + {8'd0, fc_ff};
         3'd2:    alu_r = {1'b0, regs_ff[0]} - {1'b0, alu_src};
         3'd3:    alu_r = {1'b0, regs_ff[0]} - ({1'b0, alu_src} + {8'd0, fc_ff});
         3'd4:    alu_r = {1'b0, regs_ff[0] & alu_src};
         3'd5:    alu_r = {1'b0, regs_ff[0] ^ alu_src};
         3'd6:    alu_r = {1'b0, regs_ff[0] | alu_src};
         default: alu_r = {1'b0, regs_ff[0]} - {1'b0, alu_src};
      endcase
   end

   // Execute at S_DONE for an EXEC command; pc_ff still holds the opcode address.
   logic [15:0] target;
   assign target = {rd_data_ff, opr1_ff};
   logic full, empty;
   assign full  = (sp_ff == SP_BITS'(STACK_DEPTH - 1));
   assign empty = (sp_ff == '0);

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start) begin
         cmd_ff  <= req_cmd;
         addr_ff <= req_addr;
         data_ff <= req_data;
      end
      if (state_ff == S_OPCODE) op_ff <= rd_data_ff;
      if (state_ff == S_OPER2) opr1_ff <= rd_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
         pc_ff <= '0;
         sp_ff <= '0;
         fc_ff <= 1'b0; fz_ff <= 1'b0; fs_ff <= 1'b0; fp_ff <= 1'b0;
         for (int i = 0; i < 7; i++) regs_ff[i] <= '0;
         for (int i = 0; i < STACK_DEPTH; i++) stack_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         valid_ff <= (state_ff == S_DONE);
         if (state_ff == S_DONE) begin
            status_ff <= ST_OK;
            length_ff <= 2'd0;
            if (cmd_ff == CMD_SET_PC) pc_ff <= addr_ff;
            if (cmd_ff == CMD_EXEC) begin
               length_ff <= 2'd1;
               pc_ff <= pc_ff + 16'd1;
               if (is_halt) begin
                  status_ff <= ST_HALT;
               end else begin
                  unique case (grp)
                     2'd0: begin
                        case (low)
                           3'd7, 3'd3: begin
                              if (low == 3'd7 || cond_ok) begin
                                 if (empty) pc_ff <= '0;
                                 else begin
                                    sp_ff <= sp_ff - SP_BITS'(1);
                                    pc_ff <= stack_ff[sp_ff - SP_BITS'(1)];
                                 end
                              end
                           end
                           3'd4: begin
                              pc_ff <= pc_ff + 16'd2;
                              length_ff <= 2'd2;
                              if (mid != ALU_CMP) regs_ff[0] <= alu_r[7:0];
                              fc_ff <= alu_r[8];
                              fs_ff <= alu_r[7];
                              fz_ff <= (alu_r[7:0] == 8'd0);
                              fp_ff <= ~^alu_r[7:0];
                           end
                           3'd5: begin
                              if (!full) begin
                                 stack_ff[sp_ff] <= pc_ff + 16'd1;
                                 sp_ff <= sp_ff + SP_BITS'(1);
                              end
                              pc_ff <= {10'd0, mid, 3'd0};
                           end
                           3'd6: begin
                              pc_ff <= pc_ff + 16'd2;
                              length_ff <= 2'd2;
                              if (mid != REG_M) regs_ff[mid] <= rd_data_ff;
                           end
                           default: begin
                              status_ff <= ST_ILLEGAL;
                              length_ff <= 2'd0;
                           end
                        endcase
                     end
                     2'd1: begin
                        length_ff <= 2'd3;
                        pc_ff <= pc_ff + 16'd3;
                        case (low)
                           3'd4: pc_ff <= target;
                           3'd0: if (cond_ok) pc_ff <= target;
                           3'd6, 3'd2: begin
                              if (low == 3'd6 || cond_ok) begin
                                 if (!full) begin
                                    stack_ff[sp_ff] <= pc_ff + 16'd3;
                                    sp_ff <= sp_ff + SP_BITS'(1);
                                 end
                                 pc_ff <= target;
                              end
                           end
                           default: begin
                              status_ff <= ST_ILLEGAL;
                              length_ff <= 2'd0;
                           end
                        endcase
                     end
                     2'd2: begin
                        if (mid != ALU_CMP) regs_ff[0] <= alu_r[7:0];
                        fc_ff <= alu_r[8];
                        fs_ff <= alu_r[7];
                        fz_ff <= (alu_r[7:0] == 8'd0);
                        fp_ff <= ~^alu_r[7:0];
                     end
                     default: begin
                        if (low == REG_M) regs_ff[mid] <= rd_data_ff;
                        else if (mid != REG_M) regs_ff[mid] <= regs_ff[low];
                     end
                  endcase
               end
            end
         end
      end
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_length       = length_ff;
   assign rsp_prog_counter = pc_ff;
   assign rsp_accum        = regs_ff[0];
   assign rsp_carry_flag   = fc_ff;
   assign rsp_zero_flag    = fz_ff;
   assign rsp_sign_flag    = fs_ff;
   assign rsp_parity_flag  = fp_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(state_ff == S_OPCODE))
      else $error("result strobe while an instruction is being fetched");
   a_strobe_after_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) |=> rsp_valid)
      else $error("missing result strobe");
   a_no_double: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

endmodule

### verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top: regression for cpu8008_instruction_executor
// Loads instructions and operands into the core's memory, executes them and
// compares every result strobe with a cycle-free prediction of the core.
// ---------------------------------------------------------------------------
module tb_top;
   import c8008_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int         CYCLE_LIMIT = 400000;
   localparam int         TARGET_ITEMS = 850;
   localparam int         STACK_SLOTS = 8;

   // Opcode bases; mid and low fields are or-ed in where they vary.
   localparam logic [7:0] OP_HLT     = 8'h00;
   localparam logic [7:0] OP_HLT_ALT = 8'h01;
   localparam logic [7:0] OP_HLT_FF  = 8'hff;
   localparam logic [7:0] OP_RCOND   = 8'h03;
   localparam logic [7:0] OP_ALUI    = 8'h04;
   localparam logic [7:0] OP_RST     = 8'h05;
   localparam logic [7:0] OP_MVI     = 8'h06;
   localparam logic [7:0] OP_RET     = 8'h07;
   localparam logic [7:0] OP_JCOND   = 8'h40;
   localparam logic [7:0] OP_CCOND   = 8'h42;
   localparam logic [7:0] OP_JMP     = 8'h44;
   localparam logic [7:0] OP_CALL    = 8'h46;
   localparam logic [7:0] OP_ALUR    = 8'h80;
   localparam logic [7:0] OP_MOV     = 8'hc0;
   localparam logic [7:0] OP_BAD_G0  = 8'h02;
   localparam logic [7:0] OP_BAD_G1  = 8'h41;

   localparam logic [2:0] REG_A = 3'd0;
   localparam logic [2:0] REG_B = 3'd1;
   localparam logic [2:0] REG_H = 3'd5;
   localparam logic [2:0] REG_L = 3'd6;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  length;
      logic [15:0] prog_counter;
      logic [7:0]  accum;
      logic        carry_flag;
      logic        zero_flag;
      logic        sign_flag;
      logic        parity_flag;
   } core_result_t;

   class result_scoreboard;
      core_result_t pending[$];
      int           errors;

      function void note(core_result_t r);
         pending.push_back(r);
      endfunction

      function void check(core_result_t got);
         core_result_t exp;
         if (pending.size() == 0) begin
            $error("result strobe with no command outstanding");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
         end
         if (got.length !== exp.length) begin
            $error("length: expected %0d, got %0d", exp.length, got.length);
            errors++;
         end
         if (got.prog_counter !== exp.prog_counter) begin
            $error("prog_counter: expected %h, got %h", exp.prog_counter,
                   got.prog_counter);
            errors++;
         end
         if (got.accum !== exp.accum) begin
            $error("accum: expected %h, got %h", exp.accum, got.accum);
            errors++;
         end
         if (got.carry_flag !== exp.carry_flag) begin
            $error("carry_flag: expected %b, got %b", exp.carry_flag, got.carry_flag);
            errors++;
         end
         if (got.zero_flag !== exp.zero_flag) begin
            $error("zero_flag: expected %b, got %b", exp.zero_flag, got.zero_flag);
            errors++;
         end
         if (got.sign_flag !== exp.sign_flag) begin
            $error("sign_flag: expected %b, got %b", exp.sign_flag, got.sign_flag);
            errors++;
         end
         if (got.parity_flag !== exp.parity_flag) begin
            $error("parity_flag: expected %b, got %b", exp.parity_flag,
                   got.parity_flag);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [15:0] req_addr;
   logic [7:0]  req_data;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [1:0]  rsp_length;
   logic [15:0] rsp_prog_counter;
   logic [7:0]  rsp_accum;
   logic        rsp_carry_flag;
   logic        rsp_zero_flag;
   logic        rsp_sign_flag;
   logic        rsp_parity_flag;

   cpu8008_instruction_executor dut (.*);

   result_scoreboard sb = new();

   // Shadow state of the core.
   logic [7:0]  mem_image [int];
   logic [7:0]  gpr [7];
   logic [15:0] pc_shadow;
   int          sp_shadow;
   logic [15:0] call_stack [STACK_SLOTS];
   logic        fc, fz, fs, fp;
   int          tick_count = 0;
   int          sent_count = 0;
   bit          quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      tick_count <= tick_count + 1;
      if (tick_count > CYCLE_LIMIT) begin
         $display("cpu8008_instruction_executor regression: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid)
         sb.check('{rsp_status, rsp_length, rsp_prog_counter, rsp_accum,
                    rsp_carry_flag, rsp_zero_flag, rsp_sign_flag, rsp_parity_flag});
   end

   function automatic logic [7:0] mem_read(logic [15:0] a);
      return mem_image[int'(a)];
   endfunction

   function automatic void push_return(logic [15:0] v);
      if (sp_shadow >= STACK_SLOTS - 1) return;
      call_stack[sp_shadow] = v;
      sp_shadow++;
   endfunction

   function automatic logic [15:0] pop_return();
      if (sp_shadow == 0) return 16'h0000;
      sp_shadow--;
      return call_stack[sp_shadow];
   endfunction

   function automatic bit condition_met(logic [2:0] code);
      logic f;
      case (code[1:0])
         2'd0: f = fc;
         2'd1: f = fz;
         2'd2: f = fs;
         default: f = fp;
      endcase
      return code[2] ? f : !f;
   endfunction

   function automatic void alu_apply(logic [2:0] op, logic [7:0] src);
      logic [8:0] a, s, r;
      a = {1'b0, gpr[REG_A]};
      s = {1'b0, src};
      case (op)
         3'd0: r = a + s;
         3'd1: r = a + s + fc;
         3'd2: r = a - s;
         3'd3: r = a - (s + fc);
         3'd4: r = a & s;
         3'd5: r = a ^ s;
         3'd6: r = a | s;
         default: r = a - s;
      endcase
      if (op != ALU_CMP) gpr[REG_A] = r[7:0];
      fc = r[8];
      fs = r[7];
      fz = (r[7:0] == 8'h00);
      fp = ~^r[7:0];
   endfunction

   // Executes one instruction on the shadow state; returns status and length.
   function automatic void execute_shadow(output logic [1:0] st, output logic [1:0] len);
      logic [7:0]  op, v;
      logic [1:0]  grp;
      logic [2:0]  mid, low;
      logic [15:0] hl, target;
      op  = mem_read(pc_shadow);
      grp = op[7:6];
      mid = op[5:3];
      low = op[2:0];
      hl  = {gpr[REG_H], gpr[REG_L]};
      pc_shadow = pc_shadow + 16'd1;
      st  = ST_OK;
      len = 2'd1;
      if (op == OP_HLT || op == OP_HLT_ALT || op == OP_HLT_FF) begin
         st = ST_HALT;
         return;
      end
      case (grp)
         2'd0: begin
            if (low == 3'd7) begin
               pc_shadow = pop_return();
            end else if (low == 3'd3) begin
               if (condition_met(mid)) pc_shadow = pop_return();
            end else if (low == 3'd4) begin
               v = mem_read(pc_shadow);
               pc_shadow = pc_shadow + 16'd1;
               alu_apply(mid, v);
               len = 2'd2;
            end else if (low == 3'd5) begin
               push_return(pc_shadow);
               pc_shadow = {10'd0, mid, 3'd0};
            end else if (low == 3'd6) begin
               v = mem_read(pc_shadow);
               pc_shadow = pc_shadow + 16'd1;
               if (mid == REG_M) mem_image[int'(hl)] = v;
               else gpr[mid] = v;
               len = 2'd2;
            end else begin
               st  = ST_ILLEGAL;
               len = 2'd0;
            end
         end
         2'd1: begin
            target = {mem_read(pc_shadow + 16'd1), mem_read(pc_shadow)};
            pc_shadow = pc_shadow + 16'd2;
            len = 2'd3;
            case (low)
               3'd4: pc_shadow = target;
               3'd6: begin
                  push_return(pc_shadow);
                  pc_shadow = target;
               end
               3'd0: if (condition_met(mid)) pc_shadow = target;
               3'd2: begin
                  if (condition_met(mid)) begin
                     push_return(pc_shadow);
                     pc_shadow = target;
                  end
               end
               default: begin
                  st  = ST_ILLEGAL;
                  len = 2'd0;
               end
            endcase
         end
         2'd2: alu_apply(mid, (low == REG_M) ? mem_read(hl) : gpr[low]);
         default: begin
            if (low == REG_M) gpr[mid] = mem_read(hl);
            else if (mid == REG_M) mem_image[int'(hl)] = gpr[low];
            else gpr[mid] = gpr[low];
         end
      endcase
   endfunction

   function automatic core_result_t predict_command(logic [1:0] cmd, logic [15:0] a,
                                                    logic [7:0] d);
      core_result_t r;
      logic [1:0]   st, len;
      st  = ST_OK;
      len = 2'd0;
      case (cmd)
         CMD_LOAD:   mem_image[int'(a)] = d;
         CMD_EXEC:   execute_shadow(st, len);
         CMD_SET_PC: pc_shadow = a;
         default: ;
      endcase
      r = '{st, len, pc_shadow, gpr[REG_A], fc, fz, fs, fp};
      return r;
   endfunction

   // One transfer on the command port, with a random gap before it unless quiet is set.
   task automatic send(logic [1:0] cmd, logic [15:0] a, logic [7:0] d);
      @(negedge clock);
      while (!quiet && $urandom_range(0, 99) < 15) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_cmd  = cmd;
      req_addr = a;
      req_data = d;
      while (busy) @(negedge clock);
      @(posedge clock);
      sent_count++;
      sb.note(predict_command(cmd, a, d));
   endtask

   task automatic fill_if_blank(logic [15:0] a);
      if (!mem_image.exists(int'(a))) send(CMD_LOAD, a, 8'($urandom));
   endtask

   // Places an opcode with random operands at the PC and executes it.
   task automatic run_opcode(logic [7:0] op);
      fill_if_blank({gpr[REG_H], gpr[REG_L]});
      send(CMD_LOAD, pc_shadow, op);
      send(CMD_LOAD, pc_shadow + 16'd1, 8'($urandom));
      send(CMD_LOAD, pc_shadow + 16'd2, 8'($urandom));
      send(CMD_EXEC, 16'($urandom), 8'($urandom));
   endtask

   // Executes whatever is in memory, filling any blank byte it could touch.
   task automatic run_in_place();
      fill_if_blank({gpr[REG_H], gpr[REG_L]});
      fill_if_blank(pc_shadow);
      fill_if_blank(pc_shadow + 16'd1);
      fill_if_blank(pc_shadow + 16'd2);
      send(CMD_EXEC, 16'($urandom), 8'($urandom));
   endtask

   function automatic logic [7:0] pick_opcode();
      logic [2:0] m;
      m = 3'($urandom);
      case ($urandom_range(0, 9))
         0: return OP_CALL;
         1: return OP_CCOND | {2'b00, m, 3'b000};
         2: return OP_RCOND | {2'b00, m, 3'b000};
         3: return OP_RET;
         4: return OP_ALUI | {2'b00, m, 3'b000};
         default: return 8'($urandom);
      endcase
   endfunction

   initial begin
      logic [7:0] directed [$];
      logic [2:0] k;
      bit         drained;
      drained     = 1'b0;
      quiet       = 1'b0;
      reset       = 1'b1;
      start       = 1'b0;
      req_cmd     = CMD_LOAD;
      req_addr    = 16'h0000;
      req_data    = 8'h00;
      for (int i = 0; i < 7; i++) gpr[i] = 8'h00;
      for (int i = 0; i < STACK_SLOTS; i++) call_stack[i] = 16'h0000;
      pc_shadow = 16'h0000;
      sp_shadow = 0;
      {fc, fz, fs, fp} = 4'b0000;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: halts, moves, every ALU operation, stack and flow control, illegals.
      directed = '{OP_HLT, OP_HLT_ALT, OP_HLT_FF, OP_RET, OP_MVI | 8'h38,
                   OP_MVI | 8'h28, OP_MOV | {2'b00, REG_M, REG_A},
                   OP_MOV | {2'b00, REG_A, REG_M}, OP_MOV | {2'b00, REG_A, REG_B},
                   OP_BAD_G0, OP_BAD_G1, OP_RST | 8'h18, OP_JMP, OP_JCOND,
                   OP_CCOND, OP_RCOND | 8'h20};
      foreach (directed[i]) run_opcode(directed[i]);
      for (int i = 0; i < 8; i++) begin
         k = 3'(i);
         run_opcode(OP_ALUI | {2'b00, k, 3'b000});
         run_opcode(OP_ALUR | {2'b00, k, REG_M});
      end
      // Fill the return stack past its capacity, then drain it past empty.
      for (int i = 0; i < 9; i++) run_opcode(OP_CALL);
      for (int i = 0; i < 9; i++) run_opcode(OP_RET);
      send(CMD_UNUSED, 16'hffff, 8'hff);
      send(CMD_SET_PC, 16'hffff, 8'h00);
      run_opcode(OP_JMP);

      while (sent_count < TARGET_ITEMS) begin
         quiet = (sent_count >= 350 && sent_count < 550);
         if (!drained && sent_count >= 600) begin
            drained = 1'b1;
            @(negedge clock);
            start = 1'b0;
            while (sb.pending.size() != 0) @(negedge clock);
         end
         case ($urandom_range(0, 99)) inside
            [0:4]:   send(CMD_SET_PC, 16'($urandom), 8'($urandom));
            [5:5]:   send(CMD_UNUSED, 16'($urandom), 8'($urandom));
            [6:35]:  run_in_place();
            default: run_opcode(pick_opcode());
         endcase
      end

      @(negedge clock);
      start = 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0)
         $display("cpu8008_instruction_executor regression: pass");
      else
         $display("cpu8008_instruction_executor regression: fail");
      $finish;
   end

endmodule

### cpu8008_instruction_executor.f
src/c8008_pkg.sv
src/cpu8008_instruction_executor.sv
verif/tb_top.sv
